// ----- rtl/core/slm_pkg.sv -----
// Package for the stereo level meter: display mode codes, register indexes,
// the configuration bundle and the LED ladder functions.
// No dependencies.
`timescale 1ns / 1ps

package slm_pkg;

	// Display mode codes as written in the mode register.
	typedef enum logic [1:0] {
		MODE_BAR  = 2'd0,
		MODE_DOT  = 2'd1,
		MODE_HOLD = 2'd2,
		MODE_OFF  = 2'd3
	} mode_t;

	// Register indexes, one 32-bit word each.
	localparam logic [1:0] REG_MODE        = 2'd0;
	localparam logic [1:0] REG_HOLD_LENGTH = 2'd1;
	localparam logic [1:0] REG_HOLD_RELOAD = 2'd2;
	localparam logic [1:0] REG_DECAY_STEP  = 2'd3;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Reset values of the registers.
	localparam logic [4:0] HOLD_LENGTH_RST = 5'd20;
	localparam logic [4:0] HOLD_RELOAD_RST = 5'd15;
	localparam logic [7:0] DECAY_STEP_RST  = 8'd10;

	localparam logic [7:0] MID_SCALE = 8'd128;

	// Configuration seen by both channels.
	typedef struct packed {
		mode_t      mode;
		logic [4:0] hold_length;
		logic [4:0] hold_reload;
		logic [7:0] decay_step;
	} cfg_t;

	// Distance of a raw sample from mid-scale, 0 to 128.
	function automatic logic [7:0] level_of(input logic [7:0] s);
		logic [7:0] lv;
		if (s[7]) begin
			lv = {1'b0, s[6:0]};
		end else begin
			lv = MID_SCALE - s;
		end
		return lv;
	endfunction

	// Cumulative bar ladder.
	function automatic logic [7:0] bar_leds(input logic [7:0] lv);
		logic [7:0] p;
		if (lv < 8'd5)        p = 8'h00;
		else if (lv < 8'd15)  p = 8'h01;
		else if (lv < 8'd30)  p = 8'h03;
		else if (lv < 8'd50)  p = 8'h07;
		else if (lv < 8'd70)  p = 8'h0F;
		else if (lv < 8'd90)  p = 8'h1F;
		else if (lv < 8'd120) p = 8'h3F;
		else if (lv < 8'd160) p = 8'h7F;
		else                  p = 8'hFF;
		return p;
	endfunction

	// Single-dot ladder.
	function automatic logic [7:0] dot_leds(input logic [7:0] lv);
		logic [7:0] p;
		if (lv < 8'd10)       p = 8'h00;
		else if (lv < 8'd25)  p = 8'h01;
		else if (lv < 8'd40)  p = 8'h02;
		else if (lv < 8'd55)  p = 8'h04;
		else if (lv < 8'd70)  p = 8'h08;
		else if (lv < 8'd85)  p = 8'h10;
		else if (lv < 8'd100) p = 8'h20;
		else if (lv < 8'd115) p = 8'h40;
		else                  p = 8'h80;
		return p;
	endfunction

endpackage

// ----- rtl/core/slm_cfg.sv -----
// Configuration registers of the level meter behind an APB-style port.
// Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [slm_pkg::ADDR_W-1:0]    paddr,
	input  logic [slm_pkg::DATA_W-1:0]    pwdata,
	output logic [slm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output slm_pkg::cfg_t                 cfg
);
	import slm_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_BAR;
			cfg_q.hold_length <= HOLD_LENGTH_RST;
			cfg_q.hold_reload <= HOLD_RELOAD_RST;
			cfg_q.decay_step  <= DECAY_STEP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:        cfg_q.mode        <= mode_t'(pwdata[1:0]);
				REG_HOLD_LENGTH: cfg_q.hold_length <= pwdata[4:0];
				REG_HOLD_RELOAD: cfg_q.hold_reload <= pwdata[4:0];
				REG_DECAY_STEP:  cfg_q.decay_step  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_idx)
			REG_MODE:        prdata = {30'd0, cfg_q.mode};
			REG_HOLD_LENGTH: prdata = {27'd0, cfg_q.hold_length};
			REG_HOLD_RELOAD: prdata = {27'd0, cfg_q.hold_reload};
			REG_DECAY_STEP:  prdata = {24'd0, cfg_q.decay_step};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/slm_chan.sv -----
// One meter channel: level, LED pattern and the peak-hold state.
// Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_chan (
	input  logic          clk,
	input  logic          arst_n,
	input  slm_pkg::cfg_t cfg,
	input  logic [7:0]    sample,
	input  logic          upd,
	output logic [7:0]    leds
);
	import slm_pkg::*;

	logic [7:0] peak_q;
	logic [4:0] count_q;
	logic [7:0] lv;
	logic       new_max;
	logic [7:0] peak_max;
	logic [4:0] count_max;
	logic [5:0] count_inc;
	logic       decay;
	logic [7:0] peak_nxt;
	logic [4:0] count_nxt;

	assign lv = level_of(sample);

	// Peak capture, then hold counting and decay.
	always_comb begin
		new_max   = lv > peak_q;
		peak_max  = new_max ? lv : peak_q;
		count_max = new_max ? 5'd0 : count_q;
		count_inc = {1'b0, count_max} + 6'd1;
		decay     = count_inc >= {1'b0, cfg.hold_length};
		if (decay) begin
			peak_nxt  = (peak_max >= cfg.decay_step) ? (peak_max - cfg.decay_step) : 8'd0;
			count_nxt = cfg.hold_reload;
		end else begin
			peak_nxt  = peak_max;
			count_nxt = count_inc[4:0];
		end
	end

	// Pattern by display mode.
	always_comb begin
		case (cfg.mode)
			MODE_BAR:  leds = bar_leds(lv);
			MODE_DOT:  leds = dot_leds(lv);
			MODE_HOLD: leds = bar_leds(lv) | dot_leds(peak_nxt);
			MODE_OFF:  leds = 8'h00;
			default:   leds = 8'h00;
		endcase
	end

	// Hold state moves only when an item is taken in hold mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			count_q <= '0;
		end else if (upd && cfg.mode == MODE_HOLD) begin
			peak_q  <= peak_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

// ----- rtl/core/stereo_level_meter_peak_hold_top.sv -----
// Top level of the stereo level meter with bar, dot and peak-hold modes.
// Depends on slm_pkg, slm_cfg and slm_chan.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------------
//   input    | in_valid/in_stall  | sample_a, sample_b (8 bits each)
//   output   | out_valid/out_stall| leds_a, leds_b (8 bits each)
//   config   | APB psel/penable   | paddr[3:0], pwdata, prdata (32 bits)
//
// One item per cycle sustained while the output is not stalled; each item passes
// through the input register and then the result register.
// The pattern logic and the peak update sit between those two registers.
// Reset clears the valid flags, the hold state and the configuration registers.
// When the output is stalled the result register holds and the input
// register fills; input is stalled only when both are full.
`timescale 1ns / 1ps

module stereo_level_meter_peak_hold_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 sample_a,
	input  logic [7:0]                 sample_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 leds_a,
	output logic [7:0]                 leds_b,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [slm_pkg::ADDR_W-1:0] paddr,
	input  logic [slm_pkg::DATA_W-1:0] pwdata,
	output logic [slm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import slm_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] sample_a_s1;
	logic [7:0] sample_b_s1;
	logic       valid_s2;
	logic [7:0] leds_a_s2;
	logic [7:0] leds_b_s2;
	logic       adv;
	logic       in_take;
	logic [7:0] pat_a;
	logic [7:0] pat_b;

	slm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control: stage 1 moves on when the result register is empty or not stalled.
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_a_s1 <= sample_a;
			sample_b_s1 <= sample_b;
		end
	end

	slm_chan u_chan_a (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample_a_s1),
		.upd    (adv),
		.leds   (pat_a)
	);

	slm_chan u_chan_b (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample_b_s1),
		.upd    (adv),
		.leds   (pat_b)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			leds_a_s2 <= pat_a;
			leds_b_s2 <= pat_b;
		end
	end

	assign out_valid = valid_s2;
	assign leds_a    = leds_a_s2;
	assign leds_b    = leds_b_s2;

	// A stall toward the source only happens with an item waiting in stage 1.
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	// Blank mode gives dark LEDs on both channels.
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cfg.mode == MODE_OFF) |=> (leds_a == 8'h00 && leds_b == 8'h00))
		else $error("LEDs lit in blank mode");

	// Dot mode lights at most one LED per channel.
	a_dot_single: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cfg.mode == MODE_DOT) |=> ($onehot0(leds_a) && $onehot0(leds_b)))
		else $error("more than one LED lit in dot mode");

	// Levels never exceed mid-scale, so the bar never reaches the top LED.
	a_bar_top: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cfg.mode == MODE_BAR) |=> (!leds_a[7] && !leds_b[7]))
		else $error("top LED lit in bar mode");

endmodule

// ----- sim/slm_meter_checker.sv -----
// Checker for the stereo level meter: watches the register port and both item channels,
// predicts the LED patterns of every accepted sample pair and compares them with the results.
// Depends on slm_pkg for the mode codes, register indexes and port widths.
`timescale 1ns / 1ps

module slm_meter_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [7:0]                 sample_a,
	input  logic [7:0]                 sample_b,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [7:0]                 leds_a,
	input  logic [7:0]                 leds_b,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [slm_pkg::ADDR_W-1:0] paddr,
	input  logic [slm_pkg::DATA_W-1:0] pwdata,
	output int unsigned                fail_count,
	output int unsigned                pending
);
	import slm_pkg::*;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
	} led_pair_t;

	// Shadow copy of the registers, as seen on the register port.
	mode_t      shown_mode;
	logic [4:0] peak_hold_len;
	logic [4:0] peak_reload;
	logic [7:0] peak_decay;

	// Shadow copy of the per-channel peak-hold state.
	logic [7:0] peak_level [2];
	logic [4:0] peak_age [2];

	led_pair_t   expected_leds [$];
	int unsigned mismatches = 0;
	int unsigned waiting = 0;

	assign fail_count = mismatches;
	assign pending    = waiting;

	// Distance of a raw sample from mid-scale.
	function automatic logic [7:0] distance_from_mid(input logic [7:0] raw);
		return (raw >= 8'd128) ? raw - 8'd128 : 8'd128 - raw;
	endfunction

	// Each bar bound that the level reaches lights one more LED from the bottom.
	function automatic logic [7:0] bar_pattern(input logic [7:0] lv);
		logic [7:0] bounds [8];
		logic [8:0] p;
		bounds = '{8'd5, 8'd15, 8'd30, 8'd50, 8'd70, 8'd90, 8'd120, 8'd160};
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (lv >= bounds[i]) p = {p[7:0], 1'b1};
		end
		return p[7:0];
	endfunction

	// The highest dot bound that the level reaches picks the single lit LED.
	function automatic logic [7:0] dot_pattern(input logic [7:0] lv);
		logic [7:0] bounds [8];
		logic [7:0] p;
		bounds = '{8'd10, 8'd25, 8'd40, 8'd55, 8'd70, 8'd85, 8'd100, 8'd115};
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (lv >= bounds[i]) p = 8'(1 << i);
		end
		return p;
	endfunction

	// Peak update of one channel in hold mode, then the bar with the peak dot.
	function automatic logic [7:0] hold_channel_leds(input int ch, input logic [7:0] lv);
		logic [5:0] next_age;
		if (lv > peak_level[ch]) begin
			peak_level[ch] = lv;
			peak_age[ch]   = '0;
		end
		next_age = {1'b0, peak_age[ch]} + 6'd1;
		if (next_age >= {1'b0, peak_hold_len}) begin
			peak_level[ch] = (peak_level[ch] >= peak_decay) ? peak_level[ch] - peak_decay : 8'd0;
			peak_age[ch]   = peak_reload;
		end else begin
			peak_age[ch] = next_age[4:0];
		end
		return bar_pattern(lv) | dot_pattern(peak_level[ch]);
	endfunction

	// LED patterns for one accepted sample pair.
	function automatic led_pair_t meter_tick(input logic [7:0] raw_a, input logic [7:0] raw_b);
		logic [7:0] lv_a;
		logic [7:0] lv_b;
		led_pair_t  r;
		lv_a = distance_from_mid(raw_a);
		lv_b = distance_from_mid(raw_b);
		case (shown_mode)
			MODE_BAR: begin
				r.a = bar_pattern(lv_a);
				r.b = bar_pattern(lv_b);
			end
			MODE_DOT: begin
				r.a = dot_pattern(lv_a);
				r.b = dot_pattern(lv_b);
			end
			MODE_HOLD: begin
				r.a = hold_channel_leds(0, lv_a);
				r.b = hold_channel_leds(1, lv_b);
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

	// Track register writes, predict accepted items and compare accepted results.
	always @(posedge clk or negedge arst_n) begin : watch
		led_pair_t want;
		if (!arst_n) begin
			shown_mode     = MODE_BAR;
			peak_hold_len  = HOLD_LENGTH_RST;
			peak_reload    = HOLD_RELOAD_RST;
			peak_decay     = DECAY_STEP_RST;
			peak_level[0]  = '0;
			peak_level[1]  = '0;
			peak_age[0]    = '0;
			peak_age[1]    = '0;
			expected_leds.delete();
			waiting = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MODE:        shown_mode    = mode_t'(pwdata[1:0]);
					REG_HOLD_LENGTH: peak_hold_len = pwdata[4:0];
					REG_HOLD_RELOAD: peak_reload   = pwdata[4:0];
					REG_DECAY_STEP:  peak_decay    = pwdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_leds.push_back(meter_tick(sample_a, sample_b));
			end
			if (out_valid && !out_stall) begin
				if (expected_leds.size() == 0) begin
					$error("result with nothing expected: leds_a %02h leds_b %02h",
						leds_a, leds_b);
					mismatches++;
				end else begin
					want = expected_leds.pop_front();
					if (leds_a !== want.a) begin
						$error("leds_a expected %02h actual %02h", want.a, leds_a);
						mismatches++;
					end
					if (leds_b !== want.b) begin
						$error("leds_b expected %02h actual %02h", want.b, leds_b);
						mismatches++;
					end
				end
			end
			waiting = expected_leds.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Top of the level meter testbench: clock, reset, register writes, sample pair stimulus
// with random idling on both channels, and the final verdict.
// Depends on slm_pkg, stereo_level_meter_peak_hold_top and slm_meter_checker.
`timescale 1ns / 1ps

module testbench;
	import slm_pkg::*;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [7:0]        sample_a  = '0;
	logic [7:0]        sample_b  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        leds_a;
	logic [7:0]        leds_b;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int unsigned       fail_count;
	int unsigned       pending;

	// Set for a stretch with no idling on either side.
	bit calm = 1'b0;
	// Asks the receiver for one long hold-off.
	bit long_stall_req = 1'b0;

	// Levels at the ladder bounds, used by the directed items.
	logic [7:0] ladder_levels [16] = '{
		8'd0, 8'd5, 8'd15, 8'd30, 8'd50, 8'd70, 8'd90, 8'd120,
		8'd128, 8'd10, 8'd25, 8'd40, 8'd55, 8'd85, 8'd100, 8'd115
	};

	stereo_level_meter_peak_hold_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_a  (sample_a),
		.sample_b  (sample_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.leds_a    (leds_a),
		.leds_b    (leds_b),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	slm_meter_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.leds_a     (leds_a),
		.leds_b     (leds_b),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock with a 10 ns period.
	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off counted here on request.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				hold_left      = 60;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 25);
			end
		end
	end

	// One register write: setup cycle, then access cycle until pready.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(input mode_t m, input logic [4:0] len, input logic [4:0] rel,
			input logic [7:0] step);
		reg_write(REG_MODE, {30'd0, m});
		reg_write(REG_HOLD_LENGTH, {27'd0, len});
		reg_write(REG_HOLD_RELOAD, {27'd0, rel});
		reg_write(REG_DECAY_STEP, {24'd0, step});
	endtask

	// Offer one sample pair, with random idle cycles before it, until accepted.
	task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stop offering items and wait until every expected result has come.
	task automatic drain_meter();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(negedge clk);
	endtask

	// Mostly a decaying envelope with random jumps, sometimes a uniform raw sample.
	task automatic next_sample(inout int unsigned env, output logic [7:0] s);
		int unsigned dev;
		if ($urandom_range(0, 99) < 30) begin
			s = 8'($urandom_range(0, 255));
		end else begin
			if ($urandom_range(0, 9) == 0) env = $urandom_range(0, 128);
			else if (env > 2) env -= 2;
			dev = $urandom_range(0, env);
			s   = $urandom_range(0, 1) ? 8'(128 + dev) : 8'(128 - dev);
		end
	endtask

	// Stimulus and verdict.
	initial begin : stimulus
		int unsigned env_a;
		int unsigned env_b;
		logic [7:0]  a;
		logic [7:0]  b;
		mode_t       m;
		logic [4:0]  len;
		logic [4:0]  rel;
		logic [7:0]  step;
		env_a = 64;
		env_b = 100;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bar mode from reset: every ladder bound, above and below mid-scale.
		for (int i = 0; i < 8; i++) begin
			send_pair(8'(128 + ladder_levels[i]), 8'(128 - ladder_levels[i + 8]));
		end
		drain_meter();

		// Dot mode over the same bounds, channels swapped.
		reg_write(REG_MODE, {30'd0, MODE_DOT});
		for (int i = 0; i < 8; i++) begin
			send_pair(8'(128 - ladder_levels[i + 8]), 8'(128 + ladder_levels[i]));
		end
		drain_meter();

		// Hold mode with a reload above the hold length: the peak decays on every tick that sets no new peak.
		load_settings(MODE_HOLD, 5'd2, 5'd5, 8'd30);
		send_pair(8'd0, 8'd200);
		send_pair(8'd128, 8'd128);
		send_pair(8'd128, 8'd255);
		send_pair(8'd68, 8'd128);
		send_pair(8'd128, 8'd128);
		send_pair(8'd127, 8'd129);
		drain_meter();

		// Blank mode.
		reg_write(REG_MODE, {30'd0, MODE_OFF});
		send_pair(8'd0, 8'd255);
		send_pair(8'd255, 8'd0);
		drain_meter();

		// Random phases, the first ones at the register extremes.
		for (int p = 0; p < 11; p++) begin
			len  = $urandom_range(0, 1) ? 5'($urandom_range(1, 8)) : 5'($urandom_range(0, 31));
			rel  = 5'($urandom_range(0, 31));
			step = $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(0, 255));
			m    = ($urandom_range(0, 9) < 6) ? MODE_HOLD : mode_t'($urandom_range(0, 3));
			case (p)
				0: load_settings(MODE_HOLD, 5'd31, 5'd31, 8'd0);
				1: load_settings(MODE_HOLD, 5'd1, 5'd0, 8'd128);
				2: load_settings(MODE_HOLD, 5'd0, 5'd31, 8'd255);
				3: load_settings(MODE_BAR, len, rel, step);
				4: load_settings(MODE_DOT, len, rel, step);
				5: load_settings(MODE_OFF, len, rel, step);
				default: load_settings(m, len, rel, step);
			endcase
			calm = (p == 6);
			if (p == 7) long_stall_req = 1'b1;
			repeat (57) begin
				next_sample(env_a, a);
				next_sample(env_b, b);
				send_pair(a, b);
			end
			calm = 1'b0;
			drain_meter();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
